// ----- rtl/sorted_page_mark_set_assert.svh -----
// Assertion helpers for the RTL.
// Both expect clk and rst_n in scope.
`ifndef SORTED_PAGE_MARK_SET_ASSERT_SVH
`define SORTED_PAGE_MARK_SET_ASSERT_SVH

// same-cycle implication
`define SPS_CHK_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sps check failed");

// next-cycle implication
`define SPS_CHK_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sps check failed");

`endif

// ----- rtl/sps_pkg.sv -----
`default_nettype none
package sps_pkg;

    localparam int MAX_MARKS = 64;
    localparam int PAGE_BITS = 16;
    localparam int CNT_W     = $clog2(MAX_MARKS + 1);

    localparam logic [2:0] ACT_CLEAR  = 3'd0;
    localparam logic [2:0] ACT_TOGGLE = 3'd1;
    localparam logic [2:0] ACT_INSERT = 3'd2;
    localparam logic [2:0] ACT_NEXT   = 3'd3;
    localparam logic [2:0] ACT_QUERY  = 3'd4;

    typedef struct packed {
        logic [2:0]           action;
        logic [PAGE_BITS-1:0] page;
    } sps_cmd_t;

    typedef struct packed {
        logic                 was_present;
        logic [PAGE_BITS-1:0] next_page;
        logic                 set_empty;
        logic                 full_reject;
        logic [CNT_W-1:0]     mark_count;
    } sps_res_t;

    // per-cell control from the sequencer
    typedef struct packed {
        logic cmp;   // capture compare flags against the probe
        logic ins;   // open a slot at the insert position
        logic rem;   // close the slot at the match position
    } sps_cell_cmd_t;

    typedef struct packed {
        logic lt;
        logic eq;
        logic gt;
    } sps_flags_t;

    // reduced view of the chain for the sequencer
    typedef struct packed {
        logic                 present;
        logic                 any_gt;
        logic                 head_lt;
        logic [PAGE_BITS-1:0] head_val;
        logic [PAGE_BITS-1:0] second_val;
        logic [PAGE_BITS-1:0] succ_val;
    } sps_view_t;

endpackage
`default_nettype wire

// ----- rtl/sps_cell.sv -----
`default_nettype none
module sps_cell
    import sps_pkg::*;
(
    input  wire logic                 clk,
    input  wire sps_cell_cmd_t        cmd,
    input  wire logic [PAGE_BITS-1:0] probe,
    input  wire logic                 occ,
    input  wire logic [PAGE_BITS-1:0] fill,
    input  wire logic [PAGE_BITS-1:0] left_val,
    input  wire logic [PAGE_BITS-1:0] right_val,
    input  wire logic                 left_lt,
    input  wire logic                 left_gt,
    output sps_flags_t                flags,
    output logic [PAGE_BITS-1:0]      val,
    output logic [PAGE_BITS-1:0]      hit
);

    logic [PAGE_BITS-1:0] val_reg, val_next;
    sps_flags_t           flags_reg, flags_next;

    always_comb
    begin
        flags_next = flags_reg;
        if (cmd.cmp)
        begin
            flags_next.lt = occ && (val_reg < probe);
            flags_next.eq = occ && (val_reg == probe);
            flags_next.gt = occ && (val_reg > probe);
        end
    end

    always_comb
    begin
        val_next = val_reg;
        if (cmd.ins && !flags_reg.lt)
        begin
            val_next = left_lt ? fill : left_val;
        end
        else if (cmd.rem && !flags_reg.lt)
        begin
            val_next = right_val;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg   <= val_next;
        flags_reg <= flags_next;
    end

    // first cell above the probe drives its value onto the OR bus
    assign hit   = (flags_reg.gt && !left_gt) ? val_reg : '0;
    assign val   = val_reg;
    assign flags = flags_reg;

endmodule
`default_nettype wire

// ----- rtl/sps_ctrl.sv -----
`default_nettype none
module sps_ctrl
    import sps_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cmd_valid,
    output logic                      cmd_stall,
    input  wire sps_cmd_t             cmd_word,
    output logic                      res_valid,
    input  wire logic                 res_stall,
    output sps_res_t                  res_word,
    input  wire sps_view_t            view,
    output sps_cell_cmd_t             cell_cmd,
    output logic [PAGE_BITS-1:0]      fill,
    output logic [CNT_W-1:0]          total
);

    `include "sorted_page_mark_set_assert.svh"

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } state_t;

    state_t               state_reg, state_next;
    logic [2:0]           action_reg;
    logic [PAGE_BITS-1:0] page_reg;
    logic [CNT_W-1:0]     total_reg, total_next;
    logic                 res_valid_reg, res_valid_next;
    sps_res_t             res_reg, res_next;

    logic accept, go, want_ins, do_ins, do_rem, is_full;
    logic [PAGE_BITS-1:0] smallest;

    assign accept   = (state_reg == ST_IDLE) && cmd_valid;
    assign go       = (state_reg == ST_EXEC) && (!res_valid_reg || !res_stall);
    assign is_full  = (total_reg == CNT_W'(MAX_MARKS));
    assign want_ins = !view.present &&
                      ((action_reg == ACT_TOGGLE) || (action_reg == ACT_INSERT));
    assign do_ins   = want_ins && !is_full;
    assign do_rem   = view.present && (action_reg == ACT_TOGGLE);

    always_comb
    begin
        case (action_reg)
            ACT_CLEAR:  total_next = '0;
            ACT_TOGGLE: total_next = do_rem ? total_reg - 1'b1 :
                                     do_ins ? total_reg + 1'b1 : total_reg;
            ACT_INSERT: total_next = do_ins ? total_reg + 1'b1 : total_reg;
            default:    total_next = total_reg;
        endcase
    end

    // lowest mark of the updated set
    always_comb
    begin
        if (do_ins && !view.head_lt)
            smallest = page_reg;
        else if (do_rem && !view.head_lt)
            smallest = view.second_val;
        else
            smallest = view.head_val;
    end

    always_comb
    begin
        res_next             = res_reg;
        res_valid_next       = res_valid_reg && res_stall;
        state_next           = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                    state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                if (go)
                begin
                    state_next           = ST_IDLE;
                    res_valid_next       = 1'b1;
                    res_next.was_present = view.present;
                    res_next.full_reject = want_ins && is_full;
                    res_next.mark_count  = total_next;
                    res_next.set_empty   = (total_next == '0);
                    if (total_next == '0)
                        res_next.next_page = page_reg;
                    else if (view.any_gt)
                        res_next.next_page = view.succ_val;
                    else
                        res_next.next_page = smallest;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            total_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
            if (go)
                total_reg <= total_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
        if (accept)
        begin
            action_reg <= cmd_word.action;
            page_reg   <= cmd_word.page;
        end
    end

    assign cmd_stall    = (state_reg != ST_IDLE);
    assign res_valid    = res_valid_reg;
    assign res_word     = res_reg;
    assign cell_cmd.cmp = accept;
    assign cell_cmd.ins = go && do_ins;
    assign cell_cmd.rem = go && do_rem;
    assign fill         = page_reg;
    assign total        = total_reg;

    `SPS_CHK_IMP(a_total_bound, 1'b1, total_reg <= CNT_W'(MAX_MARKS))
    `SPS_CHK_NXT(a_accept_exec, accept, state_reg == ST_EXEC)
    `SPS_CHK_IMP(a_reject_full, res_valid_reg && res_reg.full_reject,
                 res_reg.mark_count == CNT_W'(MAX_MARKS))
    `SPS_CHK_IMP(a_empty_count, res_valid_reg,
                 res_reg.set_empty == (res_reg.mark_count == '0))
    `SPS_CHK_IMP(a_ins_rem_excl, go, !(do_ins && do_rem))

endmodule
`default_nettype wire

// ----- rtl/sorted_page_mark_set.sv -----
// An accepted command word runs an accept step, then an execute step, and
// no new word is taken until the execute step ends. The accept step latches
// the compare flags in every cell of the chain; the execute step shifts the
// chain and forms the result. A result word waiting at the output holds off
// the shift step only. Reset clears the mark count and the handshake state;
// cell contents stay undefined, and no clearing pass runs.
`default_nettype none
module sorted_page_mark_set
    import sps_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     cmd_valid,
    output logic          cmd_stall,
    input  wire sps_cmd_t cmd_word,
    output logic          res_valid,
    input  wire logic     res_stall,
    output sps_res_t      res_word
);

    sps_cell_cmd_t        cell_cmd;
    sps_view_t            view;
    logic [PAGE_BITS-1:0] fill;
    logic [CNT_W-1:0]     total;

    // chain wiring: each cell sees its neighbors' values and its left neighbor's flags
    sps_flags_t           flags [MAX_MARKS];
    logic [PAGE_BITS-1:0] vals  [MAX_MARKS];
    logic [PAGE_BITS-1:0] hits  [MAX_MARKS];

    sps_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd_word  (cmd_word),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_word  (res_word),
        .view      (view),
        .cell_cmd  (cell_cmd),
        .fill      (fill),
        .total     (total)
    );

    for (genvar i = 0; i < MAX_MARKS; i++)
    begin : g_cell
        logic [PAGE_BITS-1:0] lv, rv;
        logic                 llt, lgt, occ;

        // cells below the mark count hold live marks, in ascending order
        assign occ = (total > CNT_W'(i));

        if (i == 0)
        begin : g_head
            // head sees "left is below" so an insert at slot 0 takes the page
            assign lv  = vals[0];
            assign llt = 1'b1;
            assign lgt = 1'b0;
        end
        else
        begin : g_body
            assign lv  = vals[i-1];
            assign llt = flags[i-1].lt;
            assign lgt = flags[i-1].gt;
        end

        if (i == MAX_MARKS - 1)
        begin : g_tail
            assign rv = vals[i];
        end
        else
        begin : g_mid
            assign rv = vals[i+1];
        end

        sps_cell u_cell (
            .clk       (clk),
            .cmd       (cell_cmd),
            .probe     (cmd_word.page),
            .occ       (occ),
            .fill      (fill),
            .left_val  (lv),
            .right_val (rv),
            .left_lt   (llt),
            .left_gt   (lgt),
            .flags     (flags[i]),
            .val       (vals[i]),
            .hit       (hits[i])
        );
    end

    // one-hot successor select and membership, ORed across the row
    always_comb
    begin
        view.present    = 1'b0;
        view.any_gt     = 1'b0;
        view.succ_val   = '0;
        view.head_lt    = flags[0].lt;
        view.head_val   = vals[0];
        view.second_val = vals[1];
        for (int k = 0; k < MAX_MARKS; k++)
        begin
            view.present  = view.present | flags[k].eq;
            view.any_gt   = view.any_gt | flags[k].gt;
            view.succ_val = view.succ_val | hits[k];
        end
    end

endmodule
`default_nettype wire

// ----- dv/tb.sv -----
`timescale 1ns / 100ps

module tb;
    import sps_pkg::*;

    // Spare action codes; the block answers them like a query.
    localparam logic [2:0] ACT_SPARE_LO = 3'd5;
    localparam logic [2:0] ACT_SPARE_HI = 3'd7;

    localparam int PAGE_TOP     = (1 << PAGE_BITS) - 1;
    localparam int RAND_WORDS   = 1500;
    localparam int DRAIN_CYCLES = 8;
    // Slowest honest run: ~1650 words, each with idle time from the sender,
    // stalls at the receiver and its passage through the block.
    // CYCLE_LIMIT is set at ten times a generous bound on that.
    localparam int CYCLE_LIMIT  = 400000;

    // receiver stall styles
    typedef enum logic [1:0] {RX_FREE, RX_LIGHT, RX_HEAVY, RX_RUNS} rx_mode_t;

    logic     clk       = 1'b0;
    logic     rst_n     = 1'b0;
    logic     cmd_valid = 1'b0;
    logic     cmd_stall;
    sps_cmd_t cmd_word  = '0;
    logic     res_valid;
    logic     res_stall = 1'b0;
    sps_res_t res_word;

    sorted_page_mark_set DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd_word  (cmd_word),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_word  (res_word)
    );

    // Shadow of the mark set: ascending, no duplicates, mark_cnt entries valid.
    logic [PAGE_BITS-1:0] marks [0:MAX_MARKS-1];
    int                   mark_cnt = 0;

    sps_cmd_t cmd_backlog[$];   // words waiting for the sender
    sps_res_t due_results[$];   // results owed by the block, oldest first

    int err_cnt     = 0;
    int queued_cnt  = 0;
    int res_cnt     = 0;
    int hit_cnt     = 0;
    int reject_cnt  = 0;
    int full_cnt    = 0;
    int cycle_cnt   = 0;

    // Sender burst state.
    int burst_left = 0;
    int gap_left   = 0;

    // Receiver stall state.
    rx_mode_t stall_mode = RX_FREE;
    int       mode_left  = 0;
    int       stall_left = 0;
    logic     stall_nxt;
    sps_res_t got_want;

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Apply one command word to the shadow set and return the result word
    // the block owes for it. next_page is evaluated after the update.
    function automatic sps_res_t apply_mark_word(sps_cmd_t cmd);
        int       pos;
        int       i;
        logic     hit;
        logic     refused;
        logic     found;
        sps_res_t r;
        pos = 0;
        while (pos < mark_cnt && marks[pos] < cmd.page)
            pos++;
        hit     = (pos < mark_cnt) && (marks[pos] == cmd.page);
        refused = 1'b0;
        case (cmd.action)
            ACT_CLEAR:
            begin
                mark_cnt = 0;
            end
            ACT_TOGGLE, ACT_INSERT:
            begin
                if (hit)
                begin
                    // toggle of a present page drops it, even on a full set
                    if (cmd.action == ACT_TOGGLE)
                    begin
                        for (i = pos; i + 1 < mark_cnt; i++)
                            marks[i] = marks[i + 1];
                        mark_cnt--;
                    end
                end
                else if (mark_cnt >= MAX_MARKS)
                begin
                    refused = 1'b1;
                end
                else
                begin
                    for (i = mark_cnt; i > pos; i--)
                        marks[i] = marks[i - 1];
                    marks[pos] = cmd.page;
                    mark_cnt++;
                end
            end
            default:
            begin
            end
        endcase
        // successor with wrap; an empty set hands back the page itself
        r.next_page = cmd.page;
        found       = 1'b0;
        for (i = 0; i < mark_cnt; i++)
        begin
            if (!found && marks[i] > cmd.page)
            begin
                r.next_page = marks[i];
                found       = 1'b1;
            end
        end
        if (!found && mark_cnt > 0)
            r.next_page = marks[0];
        r.was_present = hit;
        r.set_empty   = (mark_cnt == 0);
        r.full_reject = refused;
        r.mark_count  = CNT_W'(mark_cnt);
        return r;
    endfunction

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got)
        begin
            $error("%s mismatch: expected %0h, got %0h", name, want, got);
            err_cnt++;
        end
    endfunction

    task automatic queue_word(logic [2:0] act, int page);
        sps_cmd_t c;
        c.action = act;
        c.page   = page[PAGE_BITS-1:0];
        cmd_backlog.insert(cmd_backlog.size(), c);
        queued_cnt++;
    endtask

    function automatic logic traffic_pending();
        return cmd_backlog.size() != 0 || cmd_valid || due_results.size() != 0;
    endfunction

    // ------------------------------------------------------------------
    // Driver: bursts of words with random gaps; a stalled word is held.
    // The shadow set is stepped at the edge where a word is taken.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cmd_valid && !cmd_stall)
                due_results.insert(due_results.size(), apply_mark_word(cmd_word));
            if (!cmd_valid || !cmd_stall)
            begin
                if (gap_left > 0 || cmd_backlog.size() == 0)
                begin
                    if (gap_left > 0)
                        gap_left--;
                    cmd_valid <= 1'b0;
                end
                else
                begin
                    cmd_valid <= 1'b1;
                    cmd_word  <= cmd_backlog.pop_front();
                    if (burst_left <= 1)
                    begin
                        // a zero gap now and then gives back-to-back stretches
                        burst_left = $urandom_range(1, 24);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end
                    else
                    begin
                        burst_left--;
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: checks each taken result word against the oldest one owed,
    // and drives res_stall from a randomly chosen stall mode.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (res_valid && !res_stall)
            begin
                if (due_results.size() == 0)
                begin
                    $error("result word %h arrived with nothing owed", res_word);
                    err_cnt++;
                end
                else
                begin
                    got_want = due_results.pop_front();
                    check_field("was_present", got_want.was_present, res_word.was_present);
                    check_field("next_page", got_want.next_page, res_word.next_page);
                    check_field("set_empty", got_want.set_empty, res_word.set_empty);
                    check_field("full_reject", got_want.full_reject, res_word.full_reject);
                    check_field("mark_count", got_want.mark_count, res_word.mark_count);
                    res_cnt++;
                    hit_cnt    += got_want.was_present;
                    reject_cnt += got_want.full_reject;
                    if (got_want.mark_count == CNT_W'(MAX_MARKS))
                        full_cnt++;
                end
            end

            if (mode_left == 0)
            begin
                stall_mode = rx_mode_t'($urandom_range(0, 3));
                mode_left  = $urandom_range(40, 400);
            end
            else
            begin
                mode_left--;
            end

            if (stall_left > 0)
            begin
                stall_left--;
            end
            else
            begin
                case (stall_mode)
                    RX_FREE:
                    begin
                        stall_nxt  = 1'b0;
                        stall_left = $urandom_range(0, 30);
                    end
                    RX_LIGHT:
                    begin
                        stall_nxt  = ($urandom_range(0, 2) == 0);
                        stall_left = 0;
                    end
                    RX_HEAVY:
                    begin
                        stall_nxt  = ($urandom_range(0, 3) != 0);
                        stall_left = $urandom_range(0, 2);
                    end
                    default:
                    begin
                        stall_nxt  = !res_stall;
                        stall_left = $urandom_range(0, 10);
                    end
                endcase
                res_stall <= stall_nxt;
            end
        end
    end

    // Watchdog.
    initial
    begin
        while (cycle_cnt < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_cnt++;
        end
        $display("sorted_page_mark_set test failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus: directed words, a pause until the block has answered them
    // all, then random segments until about RAND_WORDS more are queued.
    // ------------------------------------------------------------------
    initial
    begin
        int         seg_kind;
        int         seg_len;
        int         dir_cnt;
        int         k;
        int         p;
        int         roll;
        int         base;
        logic       fresh;
        logic [2:0] act;
        int         pool[$];

        // empty set: next hands back the page, query misses
        queue_word(ACT_NEXT, 100);
        queue_word(ACT_QUERY, 0);
        // page extremes, both insert paths, insert of a present page
        queue_word(ACT_TOGGLE, 0);
        queue_word(ACT_TOGGLE, PAGE_TOP);
        queue_word(ACT_INSERT, 16'h8000);
        queue_word(ACT_INSERT, 16'h8000);
        // successor, wrap to the smallest mark, successor of the smallest
        queue_word(ACT_NEXT, 16'h8000);
        queue_word(ACT_NEXT, PAGE_TOP);
        queue_word(ACT_NEXT, 0);
        queue_word(ACT_QUERY, PAGE_TOP);
        // spare codes leave the set alone
        queue_word(ACT_SPARE_LO, 16'h8000);
        queue_word(ACT_SPARE_LO + 3'd1, 16'h1234);
        queue_word(ACT_SPARE_HI, PAGE_TOP);
        // toggles that remove, down to empty
        queue_word(ACT_TOGGLE, 0);
        queue_word(ACT_TOGGLE, 16'h8000);
        queue_word(ACT_TOGGLE, PAGE_TOP);
        queue_word(ACT_INSERT, 16'h5555);
        queue_word(ACT_INSERT, 16'hAAAA);
        queue_word(ACT_NEXT, 16'hAAAA);
        queue_word(ACT_CLEAR, PAGE_TOP);
        queue_word(ACT_CLEAR, 0);
        queue_word(ACT_NEXT, PAGE_TOP);
        dir_cnt = queued_cnt;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // hold the sender until every owed result has come back
        while (traffic_pending())
            @(negedge clk);

        while (queued_cnt < dir_cnt + RAND_WORDS)
        begin
            seg_kind = $urandom_range(0, 9);
            if (seg_kind < 2)
            begin
                // fill the set to or near capacity, then hammer it
                queue_word(ACT_CLEAR, $urandom_range(0, PAGE_TOP));
                pool.delete();
                seg_len = $urandom_range(66, 80);
                for (k = 0; k < seg_len; k++)
                begin
                    fresh = (pool.size() == 0) || ($urandom_range(0, 9) != 0);
                    if (fresh)
                    begin
                        p = $urandom_range(0, PAGE_TOP);
                        pool.insert(pool.size(), p);
                        act = ($urandom_range(0, 3) == 0) ? ACT_TOGGLE : ACT_INSERT;
                    end
                    else
                    begin
                        p   = pool[$urandom_range(0, pool.size() - 1)];
                        act = ACT_INSERT;
                    end
                    queue_word(act, p);
                end
                seg_len = $urandom_range(8, 20);
                for (k = 0; k < seg_len; k++)
                begin
                    roll = $urandom_range(0, 5);
                    p    = pool[$urandom_range(0, pool.size() - 1)];
                    case (roll)
                        0: queue_word(ACT_TOGGLE, $urandom_range(0, PAGE_TOP));
                        1: queue_word(ACT_INSERT, $urandom_range(0, PAGE_TOP));
                        2: queue_word(ACT_TOGGLE, p);
                        3: queue_word(ACT_INSERT, p);
                        4: queue_word(ACT_NEXT, $urandom_range(0, PAGE_TOP));
                        default: queue_word(ACT_QUERY, p);
                    endcase
                end
            end
            else if (seg_kind < 8)
            begin
                // mixed traffic over a small pool of pages so hits are common
                if ($urandom_range(0, 3) == 0)
                    queue_word(ACT_CLEAR, $urandom_range(0, PAGE_TOP));
                pool.delete();
                base = $urandom_range(0, PAGE_TOP);
                seg_len = $urandom_range(4, 40);
                for (k = 0; k < seg_len; k++)
                begin
                    if ($urandom_range(0, 1) == 0)
                        p = (base + $urandom_range(0, 64)) & PAGE_TOP;
                    else
                        p = $urandom_range(0, PAGE_TOP);
                    pool.insert(pool.size(), p);
                end
                if ($urandom_range(0, 2) == 0)
                begin
                    p = 0;
                    pool.insert(pool.size(), p);
                    p = PAGE_TOP;
                    pool.insert(pool.size(), p);
                end
                seg_len = $urandom_range(20, 80);
                for (k = 0; k < seg_len; k++)
                begin
                    roll = $urandom_range(0, 99);
                    if (roll < 3)
                        act = ACT_CLEAR;
                    else if (roll < 33)
                        act = ACT_TOGGLE;
                    else if (roll < 58)
                        act = ACT_INSERT;
                    else if (roll < 78)
                        act = ACT_NEXT;
                    else if (roll < 93)
                        act = ACT_QUERY;
                    else
                        act = 3'($urandom_range(ACT_SPARE_LO, ACT_SPARE_HI));
                    if ($urandom_range(0, 4) == 0)
                        p = $urandom_range(0, PAGE_TOP);
                    else
                        p = pool[$urandom_range(0, pool.size() - 1)];
                    queue_word(act, p);
                end
            end
            else
            begin
                // noise: any code, any page
                seg_len = $urandom_range(5, 15);
                for (k = 0; k < seg_len; k++)
                    queue_word(3'($urandom_range(0, 7)), $urandom_range(0, PAGE_TOP));
            end
        end

        while (traffic_pending())
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("checked %0d result words over %0d cycles", res_cnt, cycle_cnt);
        $display("  %0d hits, %0d words at capacity, %0d refused inserts",
                 hit_cnt, full_cnt, reject_cnt);
        if (err_cnt == 0)
            $display("sorted_page_mark_set test passed");
        else
            $display("sorted_page_mark_set test failed");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/sps_pkg.sv
rtl/sps_cell.sv
rtl/sps_ctrl.sv
rtl/sorted_page_mark_set.sv
dv/tb.sv
